@@ rtl/dtwh_pkg.sv @@
`default_nettype none
// ============================================================================
// dtwh_pkg
// Shared types and constants for the device table with holdoff core.
// ============================================================================
package dtwh_pkg;

    localparam int ADDR_W   = 24;
    localparam int STATUS_W = 8;
    localparam int COLOR_W  = 2;
    localparam int SLOT_W   = 2;
    localparam int TICKS_W  = 16;

    localparam int IN_TDATA_W  = ADDR_W + STATUS_W;
    localparam int OUT_TDATA_W = 8;

    // Bit positions inside the status byte
    localparam int PRESENT_BIT = 2;
    localparam int COLOR_LSB   = 3;

    // Bit positions of the status byte fields inside the request tdata
    localparam int IN_PRESENT_POS = ADDR_W + PRESENT_BIT;
    localparam int IN_COLOR_LSB   = ADDR_W + COLOR_LSB;

    localparam logic [TICKS_W-1:0] LOCKOUT_RESET = 16'd102;

    // Request kind, carried on tuser
    localparam logic KIND_PACKET = 1'b0;
    localparam logic KIND_TICK   = 1'b1;

    typedef logic [ADDR_W-1:0]  addr_t;
    typedef logic [TICKS_W-1:0] ticks_t;

endpackage : dtwh_pkg
`default_nettype wire

@@ rtl/device_table_with_holdoff_core.sv @@
`default_nettype none
// ============================================================================
// device_table_with_holdoff_core
// Device address table with per-slot notification holdoff countdowns.
// ============================================================================
// Takes one request per cycle while the output is not stalled: a radio packet
// or a time tick. Each request is held in an input register, then looked up
// and applied to the slot table while its notification (if any) is loaded into
// the output register, so a result on m_axis passes through the input register
// and then the output register, and the block sustains one request per clock
// while m_axis is not stalled. The table update happens in that one pass: all
// slots are compared in parallel and all countdowns step together. A stalled
// output holds the input register, which then holds s_axis_tready low.
// Write lockout_ticks through cfg_wr_en/cfg_wr_data only while idle.
module device_table_with_holdoff_core #(
    parameter int SLOTS = 4
) (
    input  wire                                  clk,
    input  wire                                  rst_n,
    // cfg_wr_data: lockout_ticks
    input  wire                                  cfg_wr_en,
    input  wire  [dtwh_pkg::TICKS_W-1:0]         cfg_wr_data,
    input  wire                                  s_axis_tvalid,
    output logic                                 s_axis_tready,
    // s_axis_tdata: [23:0] device_address, [31:24] status_bits
    input  wire  [dtwh_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // s_axis_tuser: [0] kind
    input  wire                                  s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  wire                                  m_axis_tready,
    // m_axis_tdata: [1:0] slot, [3:2] color, [7:4] zero
    output logic [dtwh_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    // m_axis_tuser: [0] newly_added
    output logic                                 m_axis_tuser
);
    import dtwh_pkg::*;

    ticks_t                 lockout_ticks_reg;

    logic                   in_valid_reg;
    logic                   in_kind_reg;
    addr_t                  in_addr_reg;
    logic [STATUS_W-1:0]    in_status_reg;

    addr_t                  slot_addr_reg [SLOTS];
    addr_t                  slot_addr_next [SLOTS];
    logic [SLOTS-1:0]       slot_locked_reg;
    logic [SLOTS-1:0]       slot_locked_next;
    ticks_t                 countdown_reg [SLOTS];
    ticks_t                 countdown_next [SLOTS];

    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [SLOT_W-1:0]      out_slot_reg;
    logic [SLOT_W-1:0]      out_slot_next;
    logic [COLOR_W-1:0]     out_color_reg;
    logic                   out_added_reg;
    logic                   out_added_next;

    logic                   advance;
    logic [SLOTS-1:0]       match;
    logic [SLOTS-1:0]       empty;
    logic [SLOTS-1:0]       match_sel;
    logic [SLOTS-1:0]       empty_sel;
    logic [SLOTS-1:0]       arm_sel;
    logic [SLOT_W-1:0]      match_num;
    logic [SLOT_W-1:0]      empty_num;
    logic                   locked_hit;
    logic                   emit;
    ticks_t                 arm_value;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lockout_ticks_reg <= LOCKOUT_RESET;
        end
        else if (cfg_wr_en)
        begin
            lockout_ticks_reg <= cfg_wr_data;
        end
    end

    // Hold the accepted request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_kind_reg   <= s_axis_tuser;
            in_addr_reg   <= s_axis_tdata[ADDR_W-1:0];
            in_status_reg <= s_axis_tdata[IN_TDATA_W-1:ADDR_W];
        end
    end

    always_comb
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            match[i] = (slot_addr_reg[i] == in_addr_reg);
            empty[i] = (slot_addr_reg[i] == '0);
        end
        match_sel = match & (~match + 1'b1);
        empty_sel = empty & (~empty + 1'b1);
        match_num = '0;
        empty_num = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (match_sel[i])
            begin
                match_num = match_num | SLOT_W'(i);
            end
            if (empty_sel[i])
            begin
                empty_num = empty_num | SLOT_W'(i);
            end
        end
        locked_hit = |(match_sel & slot_locked_reg);
        arm_value  = (lockout_ticks_reg == '0) ? ticks_t'(1) : lockout_ticks_reg;
    end

    always_comb
    begin
        slot_addr_next   = slot_addr_reg;
        slot_locked_next = slot_locked_reg;
        countdown_next   = countdown_reg;
        arm_sel          = '0;
        emit             = 1'b0;
        out_slot_next    = match_num;
        out_added_next   = 1'b0;

        if (advance)
        begin
            if (in_kind_reg == KIND_TICK)
            begin
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (countdown_reg[i] != '0)
                    begin
                        countdown_next[i] = countdown_reg[i] - 1'b1;
                        if (countdown_reg[i] == ticks_t'(1))
                        begin
                            slot_locked_next[i] = 1'b0;
                        end
                    end
                end
            end
            else if (in_status_reg[PRESENT_BIT])
            begin
                if (|match)
                begin
                    if (!locked_hit)
                    begin
                        arm_sel = match_sel;
                        emit    = 1'b1;
                    end
                end
                else if (|empty)
                begin
                    arm_sel        = empty_sel;
                    emit           = 1'b1;
                    out_slot_next  = empty_num;
                    out_added_next = 1'b1;
                end
            end

            for (int i = 0; i < SLOTS; i++)
            begin
                if (arm_sel[i])
                begin
                    slot_addr_next[i]   = in_addr_reg;
                    slot_locked_next[i] = 1'b1;
                    countdown_next[i]   = arm_value;
                end
            end
        end

        if (advance)
        begin
            out_valid_next = emit;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                slot_addr_reg[i] <= '0;
                countdown_reg[i] <= '0;
            end
            slot_locked_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            slot_addr_reg   <= slot_addr_next;
            countdown_reg   <= countdown_next;
            slot_locked_reg <= slot_locked_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            out_slot_reg  <= out_slot_next;
            out_color_reg <= in_status_reg[COLOR_LSB +: COLOR_W];
            out_added_reg <= out_added_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_TDATA_W - SLOT_W - COLOR_W){1'b0}},
                            out_color_reg, out_slot_reg};
    assign m_axis_tuser  = out_added_reg;

endmodule : device_table_with_holdoff_core
`default_nettype wire

@@ rtl/dtwh_checker.sv @@
`default_nettype none
// ============================================================================
// dtwh_checker
// Port-level checks for the device table with holdoff core.
// ============================================================================
module dtwh_checker (
    input wire                               clk,
    input wire                               rst_n,
    input wire                               s_axis_tvalid,
    input wire                               s_axis_tready,
    input wire [dtwh_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    input wire                               s_axis_tuser,
    input wire                               m_axis_tvalid,
    input wire                               m_axis_tready,
    input wire [dtwh_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    input wire                               m_axis_tuser
);
    import dtwh_pkg::*;

    // Hold a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

    // A fresh result follows an accepted present packet
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |->
            $past(s_axis_tvalid && s_axis_tready && (s_axis_tuser == KIND_PACKET)
                  && s_axis_tdata[IN_PRESENT_POS], 2))
    else $error("result without a present packet");

    // Color comes from that packet's status byte
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |->
            m_axis_tdata[COLOR_W+SLOT_W-1:SLOT_W]
                == $past(s_axis_tdata[IN_COLOR_LSB +: COLOR_W], 2))
    else $error("result color mismatch");

    // Padding bits stay zero
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[OUT_TDATA_W-1:COLOR_W+SLOT_W] == '0)
    else $error("result padding not zero");

endmodule : dtwh_checker

bind device_table_with_holdoff_core dtwh_checker u_dtwh_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire

@@ test/device_table_with_holdoff_core_tb.sv @@
// ============================================================================
// device_table_with_holdoff_core_tb
// Self-checking bench for the device table with notification holdoff.
// ============================================================================
// Drives radio packets and time ticks into the request stream. A local copy
// of the slot table, with its lock bits and countdowns, predicts every
// notification. The bench covers these cases in turn:
//   - directed packets at the reset lockout: address zero matching an empty
//     slot, a new address written into a locked empty slot, packets without
//     the present flag, and ticks;
//   - a zero lockout, a full table and re-notification after unlock;
//   - a long output stall while requests keep coming;
//   - randomized traffic under several lockout settings.
// Both stream sides idle in random bursts, except in the last part of the run.
// ============================================================================
module device_table_with_holdoff_core_tb;
    import dtwh_pkg::*;

    localparam int NSLOTS       = 4;
    localparam int DRAIN_CYCLES = 8;
    localparam int DRAIN_LIMIT  = 20000;

    typedef struct packed {
        logic [SLOT_W-1:0]  slot;
        logic [COLOR_W-1:0] color;
        logic               added;
    } notif_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_wr_en;
    ticks_t                 cfg_wr_data;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic                   s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tuser;

    addr_t                  tbl_addr   [NSLOTS];
    logic                   tbl_locked [NSLOTS];
    ticks_t                 tbl_count  [NSLOTS];
    ticks_t                 lockout_cfg;
    notif_t                 pending_notifs [$];

    int                     err_count;
    bit                     tx_idle_on;
    bit                     rx_idle_on;
    int                     rx_hold_cycles;

    device_table_with_holdoff_core #(
        .SLOTS(NSLOTS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #(4 * 400000);
        $display("DONE: errors detected");
        $finish;
    end

    function automatic void update_device_table(logic kind, addr_t addr,
                                                logic [STATUS_W-1:0] status);
        notif_t n;
        int     hit;
        hit = -1;
        n   = '0;
        if (kind == KIND_TICK)
        begin
            for (int i = 0; i < NSLOTS; i++)
            begin
                if (tbl_count[i] != '0)
                begin
                    tbl_count[i] = tbl_count[i] - 1'b1;
                    if (tbl_count[i] == '0)
                        tbl_locked[i] = 1'b0;
                end
            end
            return;
        end
        if (!status[PRESENT_BIT])
            return;
        for (int i = 0; i < NSLOTS; i++)
            if (hit < 0 && tbl_addr[i] == addr)
                hit = i;
        if (hit >= 0)
        begin
            if (tbl_locked[hit])
                return;
            n.added = 1'b0;
        end
        else
        begin
            for (int i = 0; i < NSLOTS; i++)
                if (hit < 0 && tbl_addr[i] == '0)
                    hit = i;
            if (hit < 0)
                return;
            tbl_addr[hit] = addr;
            n.added = 1'b1;
        end
        tbl_locked[hit] = 1'b1;
        tbl_count[hit]  = (lockout_cfg == '0) ? ticks_t'(1) : lockout_cfg;
        n.slot  = hit[SLOT_W-1:0];
        n.color = status[COLOR_LSB +: COLOR_W];
        pending_notifs.push_back(n);
    endfunction

    task automatic send_request(logic kind, addr_t addr, logic [STATUS_W-1:0] status);
        int gap;
        if (tx_idle_on && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 7);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {status, addr};
        s_axis_tuser  <= kind;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        update_device_table(kind, addr, status);
    endtask

    task automatic wait_idle();
        int cycles;
        cycles = 0;
        s_axis_tvalid <= 1'b0;
        while (pending_notifs.size() != 0 && cycles < DRAIN_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_notifs.size() != 0)
        begin
            err_count++;
            $display("%0t: missing notifications, expected 0 pending, got %0d pending",
                     $time, pending_notifs.size());
            pending_notifs.delete();
        end
    endtask

    task automatic write_lockout(ticks_t value);
        wait_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        lockout_cfg = value;
    endtask

    task automatic send_random_mix(int count, int tick_pct);
        int                  r;
        addr_t               a;
        logic [STATUS_W-1:0] st;
        for (int k = 0; k < count; k++)
        begin
            r  = $urandom_range(0, 99);
            a  = addr_t'($urandom_range(0, 24'hFFFFFF));
            st = STATUS_W'($urandom_range(0, 255));
            if (r < tick_pct)
                send_request(KIND_TICK, a, st);
            else if (r < tick_pct + 10)
                send_request(KIND_PACKET, a, st);
            else
            begin
                if ($urandom_range(0, 9) != 0)
                    a = tbl_addr[$urandom_range(0, NSLOTS - 1)];
                else if ($urandom_range(0, 1) == 1)
                    a = '0;
                st[PRESENT_BIT] = 1'b1;
                send_request(KIND_PACKET, a, st);
            end
        end
    endtask

    task automatic test_reset_lockout();
        send_request(KIND_PACKET, 24'h123456, 8'hFB);
        send_request(KIND_TICK,   24'hFFFFFF, 8'hFF);
        send_request(KIND_PACKET, 24'h000000, 8'h04);
        send_request(KIND_PACKET, 24'h000000, 8'h1C);
        send_request(KIND_PACKET, 24'hFFFFFF, 8'hFF);
        send_request(KIND_PACKET, 24'hFFFFFF, 8'h0C);
        send_request(KIND_TICK,   24'h000000, 8'h00);
    endtask

    task automatic test_zero_lockout();
        write_lockout('0);
        send_request(KIND_PACKET, 24'h000001, 8'h0C);
        send_request(KIND_PACKET, 24'h800000, 8'h14);
        send_request(KIND_PACKET, 24'h5A5A5A, 8'hE4);
        send_request(KIND_PACKET, 24'hA5A5A5, 8'hFF);
        send_request(KIND_PACKET, 24'h000001, 8'h04);
        send_request(KIND_TICK,   24'hA5A5A5, 8'h5A);
        send_request(KIND_PACKET, 24'h000001, 8'h1C);
        send_request(KIND_PACKET, 24'h000000, 8'h04);
    endtask

    task automatic test_output_backpressure();
        write_lockout(ticks_t'(1));
        // hold the receiver off while packets keep notifying
        rx_hold_cycles = 150;
        for (int k = 0; k < 30; k++)
        begin
            send_request(KIND_PACKET, tbl_addr[k % NSLOTS],
                         STATUS_W'($urandom_range(0, 255)) | 8'h04);
            send_request(KIND_TICK, '0, '0);
        end
        wait_idle();
    endtask

    task automatic test_random_traffic();
        write_lockout(ticks_t'(1));
        send_random_mix(250, 35);
        write_lockout(ticks_t'(2));
        send_random_mix(250, 45);
        write_lockout(ticks_t'(5));
        send_random_mix(250, 60);
        write_lockout(ticks_t'($urandom_range(1, 16)));
        send_random_mix(250, 55);
    endtask

    task automatic test_steady_stream();
        write_lockout(ticks_t'(3));
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        send_random_mix(300, 50);
        write_lockout(16'hFFFF);
        send_random_mix(80, 30);
    endtask

    initial
    begin : rx_side
        int stall_left;
        stall_left = 0;
        m_axis_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (rx_hold_cycles > 0)
            begin
                m_axis_tready  <= 1'b0;
                rx_hold_cycles = rx_hold_cycles - 1;
            end
            else if (stall_left > 0)
            begin
                m_axis_tready <= 1'b0;
                stall_left    = stall_left - 1;
            end
            else if (rx_idle_on && $urandom_range(0, 5) == 0)
            begin
                m_axis_tready <= 1'b0;
                stall_left    = $urandom_range(1, 7) - 1;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    initial
    begin : notif_check
        notif_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
            begin
                if (pending_notifs.size() == 0)
                begin
                    err_count++;
                    $display("%0t: unexpected notification, expected none, got tdata=%h tuser=%b",
                             $time, m_axis_tdata, m_axis_tuser);
                end
                else
                begin
                    want = pending_notifs.pop_front();
                    if (m_axis_tdata[SLOT_W-1:0] !== want.slot)
                    begin
                        err_count++;
                        $display("%0t: slot mismatch, expected %0d, got %0d",
                                 $time, want.slot, m_axis_tdata[SLOT_W-1:0]);
                    end
                    if (m_axis_tdata[SLOT_W +: COLOR_W] !== want.color)
                    begin
                        err_count++;
                        $display("%0t: color mismatch, expected %0d, got %0d",
                                 $time, want.color, m_axis_tdata[SLOT_W +: COLOR_W]);
                    end
                    if (m_axis_tdata[OUT_TDATA_W-1:SLOT_W+COLOR_W] !== '0)
                    begin
                        err_count++;
                        $display("%0t: pad bits mismatch, expected 0, got %h",
                                 $time, m_axis_tdata[OUT_TDATA_W-1:SLOT_W+COLOR_W]);
                    end
                    if (m_axis_tuser !== want.added)
                    begin
                        err_count++;
                        $display("%0t: newly_added mismatch, expected %b, got %b",
                                 $time, want.added, m_axis_tuser);
                    end
                end
            end
        end
    end

    initial
    begin
        err_count      = 0;
        tx_idle_on     = 1'b1;
        rx_idle_on     = 1'b1;
        rx_hold_cycles = 0;
        rst_n         <= 1'b0;
        cfg_wr_en     <= 1'b0;
        cfg_wr_data   <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= KIND_PACKET;
        for (int i = 0; i < NSLOTS; i++)
        begin
            tbl_addr[i]   = '0;
            tbl_locked[i] = 1'b0;
            tbl_count[i]  = '0;
        end
        lockout_cfg = LOCKOUT_RESET;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_lockout();
        test_zero_lockout();
        test_output_backpressure();
        test_random_traffic();
        test_steady_stream();
        wait_idle();

        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

@@ files.f @@
rtl/dtwh_pkg.sv
rtl/device_table_with_holdoff_core.sv
rtl/dtwh_checker.sv
test/device_table_with_holdoff_core_tb.sv
